[rtl/tpm_pkg.sv]
// Shared definitions for the tolerance point matcher: command codes, field widths
// and the controller/datapath command and status bundles.
// No dependencies; every other file of the block imports this package.
package tpm_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_POINTS = 1024;
	localparam int DEF_COORD_BITS = 24;

	// Fixed field widths
	localparam int INDEX_BITS  = 16;
	localparam int RADIUS_BITS = 23;
	localparam int CMD_BITS    = 2;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(256);

	// Command codes carried on the input tuser
	localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_MATCH = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic clear;        // empty the store and reset the pointers
		logic append;       // write the incoming point at the fill count
		logic match_start;  // latch the reference point, reset the best distance
		logic skip_rd;      // read the entry at the sweep start
		logic skip_adv;     // advance the sweep start by one
		logic scan_rd;      // read the entry at the scan pointer
		logic push;         // hand the entry just read to the distance pipeline
		logic scan_first;   // scan pointer takes sweep start plus one
		logic scan_next;    // scan pointer advances by one
		logic out_load;     // load the result register
	} tpm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic start_end;    // sweep start has reached the fill count
		logic scan_end;     // scan pointer has reached the fill count
		logic below;        // entry read lies at or beyond the radius below the reference
		logic above;        // entry read lies more than the radius above the reference
		logic busy;         // distance pipeline still holds an entry
	} tpm_sts_t;

endpackage

[rtl/tpm_ctrl.sv]
// Controller of the tolerance point matcher: sequences accept, skip, scan, drain
// and result transfer. Depends on tpm_pkg for the command and status bundles.
module tpm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [tpm_pkg::CMD_BITS-1:0] s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	input  tpm_pkg::tpm_sts_t            sts,
	output tpm_pkg::tpm_cmd_t            cmd
);
	import tpm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SKIP_RD,
		ST_SKIP_EV,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// Decode state and status into datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						CMD_CLEAR: cmd.clear = 1'b1;
						CMD_LOAD:  cmd.append = 1'b1;
						CMD_MATCH: begin
							cmd.match_start = 1'b1;
							state_d         = ST_SKIP_RD;
						end
						default: ;
					endcase
				end
			end
			ST_SKIP_RD: begin
				if (sts.start_end) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.skip_rd = 1'b1;
					state_d     = ST_SKIP_EV;
				end
			end
			ST_SKIP_EV: begin
				if (sts.below) begin
					cmd.skip_adv = 1'b1;
					state_d      = ST_SKIP_RD;
				end else if (sts.above) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.push       = 1'b1;
					cmd.scan_first = 1'b1;
					state_d        = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				if (sts.scan_end) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				if (sts.above) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.push      = 1'b1;
					cmd.scan_next = 1'b1;
					state_d       = ST_SCAN_RD;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// An entry enters the pipeline only in the cycle after its read was issued
	a_push_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> $past(cmd.skip_rd || cmd.scan_rd))
		else $error("push without a preceding memory read");

	// A result appears only when leaving the result state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the result state");

	// Loading the result register always presents a result
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("result load did not raise valid");
`endif

endmodule

[rtl/tpm_dp.sv]
// Datapath of the tolerance point matcher: point store, sweep and scan pointers,
// band checks, squared-distance pipeline, best-match tracking and result register.
// Depends on tpm_pkg for widths and the command and status bundles.
module tpm_dp #(
	parameter int MAX_POINTS = tpm_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = tpm_pkg::DEF_COORD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tpm_pkg::tpm_cmd_t               cmd,
	output tpm_pkg::tpm_sts_t               sts,
	input  logic signed [COORD_BITS-1:0]    in_x,
	input  logic signed [COORD_BITS-1:0]    in_y,
	input  logic [tpm_pkg::INDEX_BITS-1:0]  in_index,
	input  logic                            cfg_we,
	input  logic [tpm_pkg::RADIUS_BITS-1:0] cfg_radius,
	output logic                            out_matched,
	output logic [tpm_pkg::INDEX_BITS-1:0]  out_ref_idx,
	output logic [tpm_pkg::INDEX_BITS-1:0]  out_pt_idx
);
	import tpm_pkg::*;

	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int EW   = 2 * COORD_BITS + INDEX_BITS;
	// Difference width: holds any coordinate difference and the radius, plus sign
	localparam int DW   = ((COORD_BITS + 1 > RADIUS_BITS + 1) ? COORD_BITS + 1
		: RADIUS_BITS + 1) + 1;
	localparam int SQW  = 2 * RADIUS_BITS;

	logic [EW-1:0] mem [MAX_POINTS];
	logic [EW-1:0] rd_q;

	logic [CNTW-1:0]        count_q;
	logic [CNTW-1:0]        start_q;
	logic [CNTW-1:0]        scan_q;
	logic [RADIUS_BITS-1:0] radius_q;

	logic signed [COORD_BITS-1:0] ref_x_q;
	logic signed [COORD_BITS-1:0] ref_y_q;
	logic [INDEX_BITS-1:0]        ref_idx_q;

	logic signed [COORD_BITS-1:0] rd_x;
	logic signed [COORD_BITS-1:0] rd_y;
	logic [INDEX_BITS-1:0]        rd_idx;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [DW-1:0] tol;
	logic [DW-1:0]        ax;
	logic [DW-1:0]        ay;
	logic                 in_box;
	logic                 full;
	logic [AW-1:0]        rd_addr;

	logic                   v_s1;
	logic                   ok_s1;
	logic [RADIUS_BITS-1:0] ax_s1;
	logic [RADIUS_BITS-1:0] ay_s1;
	logic [INDEX_BITS-1:0]  idx_s1;
	logic                   v_s2;
	logic [SQW-1:0]         ax2_s2;
	logic [SQW-1:0]         ay2_s2;
	logic [INDEX_BITS-1:0]  idx_s2;
	logic [SQW:0]           r2;

	logic [SQW-1:0]        best_q;
	logic                  found_q;
	logic [INDEX_BITS-1:0] best_idx_q;

	logic                  out_matched_q;
	logic [INDEX_BITS-1:0] out_ref_q;
	logic [INDEX_BITS-1:0] out_inp_q;

	// Unpack the entry read from the store
	assign rd_x   = rd_q[COORD_BITS-1:0];
	assign rd_y   = rd_q[2*COORD_BITS-1:COORD_BITS];
	assign rd_idx = rd_q[EW-1:2*COORD_BITS];

	// Band checks against the reference point
	assign tol    = $signed(DW'(radius_q));
	assign dy     = DW'(ref_y_q) - DW'(rd_y);
	assign dx     = DW'(ref_x_q) - DW'(rd_x);
	assign ax     = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ay     = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign in_box = (ax <= DW'(radius_q)) && (ay <= DW'(radius_q));

	assign full    = (count_q == CNTW'(MAX_POINTS));
	assign rd_addr = cmd.skip_rd ? start_q[AW-1:0] : scan_q[AW-1:0];
	assign r2      = {1'b0, ax2_s2} + {1'b0, ay2_s2};

	assign sts.start_end = (start_q >= count_q);
	assign sts.scan_end  = (scan_q >= count_q);
	assign sts.below     = (dy >= tol);
	assign sts.above     = (dy < -tol);
	assign sts.busy      = v_s1 | v_s2;

	assign out_matched = out_matched_q;
	assign out_ref_idx = out_ref_q;
	assign out_pt_idx  = out_inp_q;

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem[count_q[AW-1:0]] <= {in_index, in_y, in_x};
		end
		if (cmd.skip_rd || cmd.scan_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Fill count, sweep and scan pointers, radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			start_q  <= '0;
			scan_q   <= '0;
			radius_q <= RADIUS_RESET;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_radius;
			end
			if (cmd.clear) begin
				count_q <= '0;
				start_q <= '0;
				scan_q  <= '0;
			end else begin
				if (cmd.append && !full) begin
					count_q <= count_q + CNTW'(1);
				end
				if (cmd.skip_adv) begin
					start_q <= start_q + CNTW'(1);
				end
				if (cmd.scan_first) begin
					scan_q <= start_q + CNTW'(1);
				end else if (cmd.scan_next) begin
					scan_q <= scan_q + CNTW'(1);
				end
			end
		end
	end

	// Latch the reference point
	always_ff @(posedge clk) begin
		if (cmd.match_start) begin
			ref_x_q   <= in_x;
			ref_y_q   <= in_y;
			ref_idx_q <= in_index;
		end
	end

	// Distance pipeline: stage one holds magnitudes, stage two the squares
	always_ff @(posedge clk) begin
		ax_s1  <= ax[RADIUS_BITS-1:0];
		ay_s1  <= ay[RADIUS_BITS-1:0];
		idx_s1 <= rd_idx;
		ax2_s2 <= SQW'(ax_s1) * SQW'(ax_s1);
		ay2_s2 <= SQW'(ay_s1) * SQW'(ay_s1);
		idx_s2 <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			ok_s1 <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1  <= cmd.push;
			ok_s1 <= in_box;
			v_s2  <= v_s1 && ok_s1;
		end
	end

	// Track the closest candidate; a tie goes to the later point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.match_start) begin
			found_q <= 1'b0;
		end else if (v_s2 && (r2 <= {1'b0, best_q})) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match_start) begin
			best_q <= SQW'(radius_q) * SQW'(radius_q);
		end else if (v_s2 && (r2 <= {1'b0, best_q})) begin
			best_q     <= r2[SQW-1:0];
			best_idx_q <= idx_s2;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_matched_q <= found_q;
			out_ref_q     <= ref_idx_q;
			out_inp_q     <= found_q ? best_idx_q : '0;
		end
	end

`ifndef ASSERT_OFF
	// Sweep start never passes the fill count
	a_start_bound: assert property (@(posedge clk) disable iff (!arst_n)
		start_q <= count_q)
		else $error("sweep start beyond fill count");

	// Scan pointer never passes the fill count
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= count_q)
		else $error("scan pointer beyond fill count");

	// Each match begins with no candidate found
	a_found_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match_start |=> !found_q)
		else $error("found flag not cleared at match start");
`endif

endmodule

[rtl/tolerance_point_matcher_top.sv]
// Clear, load and unknown commands are accepted at one per cycle while the block is idle.
// A match walks a read state and an evaluate state for each point skipped or scanned,
// then drains the distance pipeline and loads the result register.
// No new command is accepted until the match has loaded its result, and a result
// still held back stalls the next match in its final state.
// Reset (arst_n, asynchronous) clears the fill count and pointers and sets the radius to 1.0.
module tolerance_point_matcher_top #(
	parameter int MAX_POINTS = tpm_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = tpm_pkg::DEF_COORD_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// s_tdata: coord_x, coord_y, point_index from bit 0 up, zero padded to bytes
	input  logic [((2*COORD_BITS+tpm_pkg::INDEX_BITS+7)/8)*8-1:0] s_tdata,
	// s_tuser: command
	input  logic [tpm_pkg::CMD_BITS-1:0]           s_tuser,
	// Result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// m_tdata: reference index, matched point index from bit 0 up
	output logic [2*tpm_pkg::INDEX_BITS-1:0]       m_tdata,
	// m_tuser: matched
	output logic                                   m_tuser,
	// Radius write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tpm_pkg::RADIUS_BITS-1:0]        cfg_data
);
	import tpm_pkg::*;

	tpm_cmd_t cmd;
	tpm_sts_t sts;

	logic signed [COORD_BITS-1:0] in_x;
	logic signed [COORD_BITS-1:0] in_y;
	logic [INDEX_BITS-1:0]        in_index;
	logic [INDEX_BITS-1:0]        res_ref_idx;
	logic [INDEX_BITS-1:0]        res_pt_idx;

	// Split the input transfer into fields
	assign in_x     = s_tdata[COORD_BITS-1:0];
	assign in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_index = s_tdata[2*COORD_BITS+INDEX_BITS-1:2*COORD_BITS];

	assign m_tdata   = {res_pt_idx, res_ref_idx};
	assign cfg_ready = 1'b1;

	tpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpm_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_x        (in_x),
		.in_y        (in_y),
		.in_index    (in_index),
		.cfg_we      (cfg_valid),
		.cfg_radius  (cfg_data),
		.out_matched (m_tuser),
		.out_ref_idx (res_ref_idx),
		.out_pt_idx  (res_pt_idx)
	);

endmodule

[dv/tb_tolerance_point_matcher_top.sv]
// Self-checking testbench for tolerance_point_matcher_top: drives clear, load and match
// commands, predicts each match result and checks every result transfer.
// Depends on tpm_pkg and the tolerance_point_matcher_top RTL only.
module tb_tolerance_point_matcher_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tpm_pkg::*;

	localparam int COORD_W    = DEF_COORD_BITS;
	localparam int MAX_PTS    = DEF_MAX_POINTS;
	localparam int TDATA_W    = ((2*COORD_W+INDEX_BITS+7)/8)*8;
	localparam logic [CMD_BITS-1:0] CMD_IGNORED = 2'd3;
	localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;
	localparam longint COORD_HI = 8388607;
	localparam longint COORD_LO = -8388608;
	// longest match walks the whole store point by point
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;
	localparam int RANDOM_ITEMS = 60;

	typedef struct {
		logic [CMD_BITS-1:0]      cmd;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [INDEX_BITS-1:0]    idx;
	} point_cmd_t;

	typedef struct {
		logic                  matched;
		logic [INDEX_BITS-1:0] ref_idx;
		logic [INDEX_BITS-1:0] pt_idx;
	} match_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_W-1:0]     s_tdata = '0;
	logic [CMD_BITS-1:0]    s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [2*INDEX_BITS-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [RADIUS_BITS-1:0] cfg_data = '0;

	tolerance_point_matcher_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // coord_x, coord_y, point_index from bit 0 up
		.s_tuser   (s_tuser),    // command
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // reference index, matched point index from bit 0 up
		.m_tuser   (m_tuser),    // matched
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Predicted block state
	logic signed [COORD_W-1:0] store_x [MAX_PTS];
	logic signed [COORD_W-1:0] store_y [MAX_PTS];
	logic [INDEX_BITS-1:0]     store_idx [MAX_PTS];
	int                        store_n = 0;
	int                        sweep_pos = 0;
	logic [RADIUS_BITS-1:0]    cur_radius = RADIUS_RESET;

	point_cmd_t    cmd_backlog[$];
	match_result_t pending_matches[$];
	point_cmd_t    offered;

	int n_queued = 0;
	int n_accepted = 0;
	int n_live = 0;
	int n_checked = 0;
	int n_hits = 0;
	int n_radius = 0;
	int err_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(input string what);
		err_cnt++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// Work out the effect of one accepted command; a match queues its result
	task automatic predict_sweep(input point_cmd_t c);
		longint rx, ry, tol, dx, dy, ax, ay, r2, best;
		bit found;
		logic [INDEX_BITS-1:0] best_idx;
		int p;
		match_result_t res;
		rx = longint'(c.x);
		ry = longint'(c.y);
		tol = longint'(cur_radius);
		found = 1'b0;
		best_idx = '0;
		if (c.cmd == CMD_CLEAR) begin
			store_n = 0;
			sweep_pos = 0;
		end else if (c.cmd == CMD_LOAD) begin
			// drop loads once the store is full
			if (store_n < MAX_PTS) begin
				store_x[store_n] = c.x;
				store_y[store_n] = c.y;
				store_idx[store_n] = c.idx;
				store_n++;
			end
		end else if (c.cmd == CMD_MATCH) begin
			// advance the sweep start past points too far below
			while (sweep_pos < store_n && ry - longint'(store_y[sweep_pos]) >= tol)
				sweep_pos++;
			if (sweep_pos < store_n && ry - longint'(store_y[sweep_pos]) >= -tol) begin
				best = tol * tol;
				for (p = sweep_pos; p < store_n; p++) begin
					dy = ry - longint'(store_y[p]);
					if (dy < -tol)
						break;
					dx = rx - longint'(store_x[p]);
					ax = (dx < 0) ? -dx : dx;
					ay = (dy < 0) ? -dy : dy;
					if (ax <= tol && ay <= tol) begin
						r2 = ax * ax + ay * ay;
						// later point wins a tie
						if (r2 <= best) begin
							best = r2;
							found = 1'b1;
							best_idx = store_idx[p];
						end
					end
				end
			end
			res.matched = found;
			res.ref_idx = c.idx;
			res.pt_idx = found ? best_idx : '0;
			pending_matches.push_back(res);
		end
	endtask

	// Input driver: offer the backlog, predict on each transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				predict_sweep(offered);
				n_accepted <= n_accepted + 1;
			end
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offered = cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {offered.idx, offered.y, offered.x};
				s_tuser <= offered.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted down on its own
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_taken) begin
			hold_left <= HOLD_CYCLES;
			hold_taken <= hold_taken + 1;
		end
	end

	// Result monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin : check_result
				match_result_t want;
				n_checked++;
				if (m_tuser)
					n_hits++;
				if (pending_matches.size() == 0) begin
					report_mismatch("result transfer with no match pending");
				end else begin
					want = pending_matches.pop_front();
					if (m_tuser !== want.matched)
						report_mismatch($sformatf("ref %0d: matched %b, want %b",
							want.ref_idx, m_tuser, want.matched));
					if (m_tdata[INDEX_BITS-1:0] !== want.ref_idx)
						report_mismatch($sformatf("reference index %0d, want %0d",
							m_tdata[INDEX_BITS-1:0], want.ref_idx));
					if (m_tdata[2*INDEX_BITS-1:INDEX_BITS] !== want.pt_idx)
						report_mismatch($sformatf("ref %0d: point index %0d, want %0d",
							want.ref_idx, m_tdata[2*INDEX_BITS-1:INDEX_BITS], want.pt_idx));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run after a long stretch with no transfer at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic longint sat_coord(input longint v);
		if (v > COORD_HI)
			return COORD_HI;
		if (v < COORD_LO)
			return COORD_LO;
		return v;
	endfunction

	function automatic longint any_coord();
		return longint'($signed(COORD_W'($urandom)));
	endfunction

	// Coordinate within about one radius of a centre
	function automatic longint jitter(input longint c, input longint u);
		return sat_coord(c + longint'($urandom_range(int'(2 * u))) - u);
	endfunction

	task automatic queue_item(input logic [CMD_BITS-1:0] cmd, input longint x,
			input longint y, input longint idx);
		point_cmd_t c;
		c.cmd = cmd;
		c.x = COORD_W'(x);
		c.y = COORD_W'(y);
		c.idx = INDEX_BITS'(idx);
		cmd_backlog.push_back(c);
		n_queued++;
		if (cmd != CMD_IGNORED)
			n_live++;
	endtask

	// Hold until every command has gone in and every result has come out
	task automatic drain();
		while (n_accepted != n_queued || pending_matches.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_radius(input logic [RADIUS_BITS-1:0] r);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_radius = r;
		n_radius++;
	endtask

	// Sorted store load followed by sorted references, with the odd late load
	task automatic queue_sweep(input int n_pts, input int n_ref);
		longint u, cx, ly, ry;
		int k;
		u = (cur_radius == 0) ? 8 : longint'(cur_radius);
		cx = any_coord();
		ly = any_coord();
		ry = ly - u;
		if ($urandom_range(4) != 0)
			queue_item(CMD_CLEAR, any_coord(), any_coord(), longint'($urandom));
		for (k = 0; k < n_pts; k++) begin
			if ($urandom_range(3) != 0)
				ly += longint'($urandom_range(int'(u)));
			queue_item(CMD_LOAD, jitter(cx, u), sat_coord(ly), longint'($urandom));
		end
		for (k = 0; k < n_ref; k++) begin
			ry += longint'($urandom_range(int'(u)));
			queue_item(CMD_MATCH, jitter(cx, u), sat_coord(ry), longint'($urandom));
			if ($urandom_range(7) == 0) begin
				ly += longint'($urandom_range(int'(u)));
				queue_item(CMD_LOAD, jitter(cx, u), sat_coord(ly), longint'($urandom));
			end
		end
	endtask

	// Unstructured commands, including the unused code
	task automatic queue_noise(input int n);
		int k;
		for (k = 0; k < n; k++)
			queue_item(CMD_BITS'($urandom_range(3)), any_coord(), any_coord(),
				longint'($urandom));
	endtask

	function automatic logic [RADIUS_BITS-1:0] pick_radius();
		case ($urandom_range(7))
			0: return '0;
			1: return RADIUS_MAX;
			2: return RADIUS_BITS'($urandom);
			default: return RADIUS_BITS'($urandom_range(4096, 1));
		endcase
	endfunction

	initial begin : stimulus
		int k;
		int phase;
		int live_base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset radius, empty store, ties, boundary, skipping
		queue_item(CMD_MATCH, 0, 0, 16'hFFFF);
		queue_item(CMD_IGNORED, -1, -1, 16'hFFFF);
		queue_item(CMD_LOAD, 0, 0, 1);
		queue_item(CMD_LOAD, 256, 0, 2);
		queue_item(CMD_LOAD, COORD_LO, 100, 16'h8000);
		queue_item(CMD_LOAD, COORD_HI, 300, 16'h7FFF);
		queue_item(CMD_MATCH, 0, 0, 10);
		queue_item(CMD_MATCH, 128, 0, 11);
		queue_item(CMD_MATCH, 0, 700, 12);
		queue_item(CMD_LOAD, 0, 800, 20);
		queue_item(CMD_MATCH, 0, 500, 13);
		queue_item(CMD_MATCH, 0, 600, 14);
		queue_item(CMD_CLEAR, 0, 0, 0);
		queue_item(CMD_MATCH, 0, 0, 15);
		// unsorted store hides a point at zero distance
		queue_item(CMD_LOAD, 0, 1000, 30);
		queue_item(CMD_LOAD, 0, 0, 31);
		queue_item(CMD_MATCH, 0, 0, 16);
		drain();
		// widest radius with points at the coordinate extremes
		write_radius(RADIUS_MAX);
		queue_item(CMD_CLEAR, COORD_HI, COORD_LO, 16'hFFFF);
		queue_item(CMD_LOAD, COORD_LO, COORD_LO, 16'hAAAA);
		queue_item(CMD_LOAD, COORD_HI, COORD_HI, 16'h5555);
		queue_item(CMD_MATCH, 0, 0, 17);
		queue_item(CMD_MATCH, COORD_HI, COORD_HI, 18);
		drain();
		write_radius('0);
		queue_item(CMD_CLEAR, 0, 0, 0);
		queue_item(CMD_LOAD, 5, 5, 1);
		queue_item(CMD_MATCH, 5, 5, 2);
		drain();

		// Fill the store, overflow it, and sweep to its far end
		write_radius(RADIUS_RESET);
		queue_item(CMD_CLEAR, 0, 0, 0);
		for (k = 0; k < MAX_PTS; k++)
			queue_item(CMD_LOAD, longint'(k), longint'(k) * 1024, longint'(k));
		queue_item(CMD_LOAD, 0, longint'(MAX_PTS) * 1024, 16'hBEEF);
		queue_item(CMD_MATCH, longint'(MAX_PTS - 1), longint'(MAX_PTS - 1) * 1024, 16'h1234);
		queue_item(CMD_MATCH, 0, longint'(MAX_PTS) * 1024, 16'h4321);
		queue_item(CMD_CLEAR, 0, 0, 0);
		drain();

		// Random sweeps under changing radius and flow control
		live_base = n_live;
		phase = 0;
		while (phase < 4 || n_live - live_base < RANDOM_ITEMS) begin
			drain();
			if (phase == 0 || $urandom_range(3) != 0)
				write_radius(pick_radius());
			case (phase % 5)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
				3: begin send_idle_pct = 24; recv_stall_pct = 24; end
				default: begin send_idle_pct = $urandom_range(50); recv_stall_pct = 0; end
			endcase
			if (phase == 1) begin
				// stall the result side while a burst of matches backs up
				send_idle_pct = 0;
				hold_req++;
				queue_sweep(8, 40);
			end else if ($urandom_range(6) == 0) begin
				queue_noise($urandom_range(30, 10));
			end else if ($urandom_range(9) == 0) begin
				queue_sweep($urandom_range(60, 20), $urandom_range(30, 10));
			end else begin
				queue_sweep($urandom_range(12, 1), $urandom_range(12, 1));
			end
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d commands over %0d sweep phases and %0d radius writes",
			n_queued, phase, n_radius);
		$display("Checked %0d results, %0d of them matches", n_checked, n_hits);
		if (err_cnt == 0 && pending_matches.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results outstanding", err_cnt, pending_matches.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
